// File: sv/onewire_temperature_reader_core_macros.svh
// Assertion macros for the one-wire temperature reader core.
`ifndef ONEWIRE_TEMPERATURE_READER_CORE_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OWTR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owtr assertion failed");
`define OWTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owtr assertion failed");
`else
`define OWTR_ASSERT_NOW(lbl, ante, cons)
`define OWTR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/owtr_pkg.sv
// Types and constants shared by the one-wire temperature reader core.
package owtr_pkg;

    localparam int CFG_WIDTH   = 20;
    localparam int TIMER_WIDTH = 20;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_HOLD = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HIGH  = 4'd5,
        PH_RECOVER  = 4'd6,
        PH_CONVERT  = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_RD_WAIT  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        CFG_RESET_LOW_TIME = 2'd0,
        CFG_PRESENCE_DELAY = 2'd1,
        CFG_SLOT_TIME      = 2'd2,
        CFG_CONVERT_WAIT   = 2'd3
    } cfg_index_t;

    localparam logic [3:0] STEP_RESET1  = 4'd0;
    localparam logic [3:0] STEP_CMD_CONVERT = 4'd2;
    localparam logic [3:0] STEP_CONVERT = 4'd3;
    localparam logic [3:0] STEP_RESET2  = 4'd4;
    localparam logic [3:0] STEP_CMD_READ = 4'd6;
    localparam logic [3:0] STEP_READ_LO = 4'd7;
    localparam logic [3:0] STEP_READ_HI = 4'd8;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [TIMER_WIDTH-1:0] READ_LOW_TICKS = 20'd2;

    localparam logic [9:0]  RESET_LOW_TIME_INIT = 10'd480;
    localparam logic [7:0]  PRESENCE_DELAY_INIT = 8'd60;
    localparam logic [7:0]  SLOT_TIME_INIT      = 8'd60;
    localparam logic [19:0] CONVERT_WAIT_INIT   = 20'd600;

    typedef struct packed {
        logic [9:0]  reset_low_time;
        logic [7:0]  presence_delay;
        logic [7:0]  slot_time;
        logic [19:0] convert_wait;
    } cfg_t;

    typedef struct packed {
        logic        bus_drive_low;
        logic        busy_res;
        logic        done_res;
        logic        no_device;
        logic [11:0] temperature;
    } res_t;

endpackage

// File: sv/owtr_in_if.sv
// Input channel: one word per bus tick carrying start request and wire level.
interface owtr_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic bus_level;

    modport source (output valid, output start_req, output bus_level, input ready);
    modport sink   (input valid, input start_req, input bus_level, output ready);
endinterface

// File: sv/owtr_out_if.sv
// Output channel: one result word per accepted input word.
interface owtr_out_if;
    logic        valid;
    logic        ready;
    logic        bus_drive_low;
    logic        busy_res;
    logic        done_res;
    logic        no_device;
    logic [11:0] temperature;

    modport source (output valid, output bus_drive_low, output busy_res, output done_res,
                    output no_device, output temperature, input ready);
    modport sink   (input valid, input bus_drive_low, input busy_res, input done_res,
                    input no_device, input temperature, output ready);
endinterface

// File: sv/owtr_cfg.sv
// Configuration register bank for the one-wire temperature reader core.
module owtr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [owtr_pkg::CFG_WIDTH-1:0] cfg_wdata,
    output owtr_pkg::cfg_t                 cfg
);

    owtr_pkg::cfg_t cfg_reg;
    owtr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (owtr_pkg::cfg_index_t'(cfg_index))
                owtr_pkg::CFG_RESET_LOW_TIME: cfg_next.reset_low_time = cfg_wdata[9:0];
                owtr_pkg::CFG_PRESENCE_DELAY: cfg_next.presence_delay = cfg_wdata[7:0];
                owtr_pkg::CFG_SLOT_TIME:      cfg_next.slot_time      = cfg_wdata[7:0];
                owtr_pkg::CFG_CONVERT_WAIT:   cfg_next.convert_wait   = cfg_wdata[19:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time <= owtr_pkg::RESET_LOW_TIME_INIT;
            cfg_reg.presence_delay <= owtr_pkg::PRESENCE_DELAY_INIT;
            cfg_reg.slot_time      <= owtr_pkg::SLOT_TIME_INIT;
            cfg_reg.convert_wait   <= owtr_pkg::CONVERT_WAIT_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/owtr_seq.sv
// Bus script sequencer: advances the one-wire state by one tick per step.
module owtr_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  logic           start_req,
    input  logic           bus_level,
    input  owtr_pkg::cfg_t cfg,
    output owtr_pkg::res_t res
);

    localparam int TW = owtr_pkg::TIMER_WIDTH;

    owtr_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]    tick_timer_reg, tick_timer_next;
    logic [3:0]       script_step_reg, script_step_next;
    logic [2:0]       bit_position_reg, bit_position_next;
    logic [7:0]       shift_byte_reg, shift_byte_next;
    logic [7:0]       low_byte_reg, low_byte_next;
    logic [11:0]      result_value_reg, result_value_next;
    logic             absent_flag_reg, absent_flag_next;

    logic [TW:0]      timer_inc;
    logic [TW-1:0]    phase_len;
    logic [TW-1:0]    timer_adv;
    logic             last_tick;
    logic [7:0]       cmd_byte;
    logic             cmd_bit;
    logic             do_enter;
    logic [3:0]       enter_sel;
    logic             do_finish;
    logic             drive;
    logic             busy;
    logic             done;

    function automatic owtr_pkg::phase_t step_phase(input logic [3:0] s);
        owtr_pkg::phase_t p;
        if (s == owtr_pkg::STEP_RESET1 || s == owtr_pkg::STEP_RESET2)
            p = owtr_pkg::PH_RST_LOW;
        else if (s == owtr_pkg::STEP_CONVERT)
            p = owtr_pkg::PH_CONVERT;
        else if (s >= owtr_pkg::STEP_READ_LO)
            p = owtr_pkg::PH_RD_LOW;
        else
            p = owtr_pkg::PH_WR_LOW;
        return p;
    endfunction

    always_comb
    begin
        if (script_step_reg == owtr_pkg::STEP_CMD_CONVERT)
            cmd_byte = owtr_pkg::CMD_CONVERT;
        else if (script_step_reg == owtr_pkg::STEP_CMD_READ)
            cmd_byte = owtr_pkg::CMD_READ_PAD;
        else
            cmd_byte = owtr_pkg::CMD_SKIP_ROM;
    end

    assign cmd_bit = cmd_byte[bit_position_reg];

    // length of the current timed phase
    always_comb
    begin
        unique case (phase_reg)
            owtr_pkg::PH_RST_LOW,
            owtr_pkg::PH_RST_HOLD: phase_len = TW'(cfg.reset_low_time);
            owtr_pkg::PH_RST_WAIT: phase_len = TW'(cfg.presence_delay);
            owtr_pkg::PH_WR_LOW:   phase_len = cmd_bit ? TW'(1) : TW'(cfg.slot_time);
            owtr_pkg::PH_WR_HIGH,
            owtr_pkg::PH_RD_WAIT:  phase_len = TW'(cfg.slot_time);
            owtr_pkg::PH_RD_LOW:   phase_len = owtr_pkg::READ_LOW_TICKS;
            owtr_pkg::PH_CONVERT:  phase_len = cfg.convert_wait;
            default:               phase_len = TW'(1);
        endcase
    end

    assign timer_inc = {1'b0, tick_timer_reg} + (TW+1)'(1);
    assign last_tick = timer_inc >= {1'b0, phase_len};
    assign timer_adv = last_tick ? '0 : timer_inc[TW-1:0];

    always_comb
    begin
        phase_next        = phase_reg;
        tick_timer_next   = tick_timer_reg;
        script_step_next  = script_step_reg;
        bit_position_next = bit_position_reg;
        shift_byte_next   = shift_byte_reg;
        low_byte_next     = low_byte_reg;
        result_value_next = result_value_reg;
        absent_flag_next  = absent_flag_reg;
        do_enter          = 1'b0;
        enter_sel         = script_step_reg + 4'd1;
        do_finish         = 1'b0;
        drive             = 1'b0;
        busy              = (phase_reg >= owtr_pkg::PH_RST_LOW) &&
                            (phase_reg <= owtr_pkg::PH_RD_WAIT);

        unique case (phase_reg)
            owtr_pkg::PH_RST_LOW:
            begin
                drive           = 1'b1;
                tick_timer_next = timer_adv;
                if (last_tick)
                    phase_next = owtr_pkg::PH_RST_WAIT;
            end
            owtr_pkg::PH_RST_WAIT:
            begin
                tick_timer_next = timer_adv;
                if (last_tick)
                begin
                    if (script_step_reg == owtr_pkg::STEP_RESET1)
                        absent_flag_next = bus_level;
                    phase_next = owtr_pkg::PH_RST_HOLD;
                end
            end
            owtr_pkg::PH_RST_HOLD:
            begin
                tick_timer_next = timer_adv;
                if (last_tick)
                begin
                    if (script_step_reg == owtr_pkg::STEP_RESET1 && absent_flag_reg)
                    begin
                        result_value_next = '0;
                        do_finish         = 1'b1;
                    end
                    else
                    begin
                        do_enter = 1'b1;
                    end
                end
            end
            owtr_pkg::PH_WR_LOW:
            begin
                drive           = 1'b1;
                tick_timer_next = timer_adv;
                if (last_tick)
                    phase_next = cmd_bit ? owtr_pkg::PH_WR_HIGH : owtr_pkg::PH_RECOVER;
            end
            owtr_pkg::PH_WR_HIGH:
            begin
                tick_timer_next = timer_adv;
                if (last_tick)
                    phase_next = owtr_pkg::PH_RECOVER;
            end
            owtr_pkg::PH_RD_LOW:
            begin
                drive           = 1'b1;
                tick_timer_next = timer_adv;
                if (last_tick)
                    phase_next = owtr_pkg::PH_RD_WAIT;
            end
            owtr_pkg::PH_RD_WAIT:
            begin
                // sample on the first released tick
                if (tick_timer_reg == '0)
                    shift_byte_next = shift_byte_reg | (8'(bus_level) << bit_position_reg);
                tick_timer_next = timer_adv;
                if (last_tick)
                    phase_next = owtr_pkg::PH_RECOVER;
            end
            owtr_pkg::PH_RECOVER:
            begin
                tick_timer_next = '0;
                if (bit_position_reg != 3'd7)
                begin
                    bit_position_next = bit_position_reg + 3'd1;
                    phase_next = (script_step_reg >= owtr_pkg::STEP_READ_LO) ?
                                 owtr_pkg::PH_RD_LOW : owtr_pkg::PH_WR_LOW;
                end
                else if (script_step_reg == owtr_pkg::STEP_READ_LO)
                begin
                    low_byte_next = shift_byte_reg;
                    do_enter      = 1'b1;
                    enter_sel     = owtr_pkg::STEP_READ_HI;
                end
                else if (script_step_reg >= owtr_pkg::STEP_READ_HI)
                begin
                    result_value_next = {shift_byte_reg, low_byte_reg[7:4]};
                    do_finish         = 1'b1;
                end
                else
                begin
                    do_enter = 1'b1;
                end
            end
            owtr_pkg::PH_CONVERT:
            begin
                tick_timer_next = timer_adv;
                if (last_tick)
                begin
                    do_enter  = 1'b1;
                    enter_sel = owtr_pkg::STEP_RESET2;
                end
            end
            default:
            begin
                phase_next = owtr_pkg::PH_IDLE;
                if (start_req)
                begin
                    absent_flag_next = 1'b0;
                    do_enter         = 1'b1;
                    enter_sel        = owtr_pkg::STEP_RESET1;
                end
            end
        endcase

        if (do_enter)
        begin
            script_step_next  = enter_sel;
            tick_timer_next   = '0;
            bit_position_next = '0;
            shift_byte_next   = '0;
            phase_next        = step_phase(enter_sel);
        end

        done = do_finish;
        if (do_finish)
        begin
            phase_next        = owtr_pkg::PH_IDLE;
            script_step_next  = '0;
            tick_timer_next   = '0;
            bit_position_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= owtr_pkg::PH_IDLE;
            tick_timer_reg   <= '0;
            script_step_reg  <= '0;
            bit_position_reg <= '0;
            shift_byte_reg   <= '0;
            low_byte_reg     <= '0;
            result_value_reg <= '0;
            absent_flag_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            tick_timer_reg   <= tick_timer_next;
            script_step_reg  <= script_step_next;
            bit_position_reg <= bit_position_next;
            shift_byte_reg   <= shift_byte_next;
            low_byte_reg     <= low_byte_next;
            result_value_reg <= result_value_next;
            absent_flag_reg  <= absent_flag_next;
        end
    end

    assign res.bus_drive_low = drive;
    assign res.busy_res      = busy;
    assign res.done_res      = done;
    assign res.no_device     = absent_flag_next;
    assign res.temperature   = result_value_next;

endmodule

// File: sv/onewire_temperature_reader_core.sv
// Top level of the one-wire temperature reader: handshake, output register, checks.
//
// Each input word is one bus tick. A word is taken in every clock cycle while
// the output register is empty or being drained, and its result word appears
// the next cycle from that register; a stalled output holds back the input.
// The sequencer state advances once per accepted word, so all bus timing is
// counted in accepted words, not in clock cycles. A start request in idle runs
// reset and presence check, Skip-ROM and Convert, the convert wait, a second
// reset, Skip-ROM and Read-Scratchpad, then reads two bytes LSB first; the
// temperature is the 16-bit reading shifted right by four. Configuration
// writes take effect on the next word.

`include "onewire_temperature_reader_core_macros.svh"

module onewire_temperature_reader_core (
    input  logic                           clk,
    input  logic                           rst_n,
    owtr_in_if.sink                        in_ch,
    owtr_out_if.source                     out_ch,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [owtr_pkg::CFG_WIDTH-1:0] cfg_wdata
);

    owtr_pkg::cfg_t cfg;
    owtr_pkg::res_t res;
    owtr_pkg::res_t res_reg;
    logic           out_valid_reg, out_valid_next;
    logic           accept;

    owtr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owtr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept),
        .start_req (in_ch.start_req),
        .bus_level (in_ch.bus_level),
        .cfg       (cfg),
        .res       (res)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bus_drive_low = res_reg.bus_drive_low;
    assign out_ch.busy_res      = res_reg.busy_res;
    assign out_ch.done_res      = res_reg.done_res;
    assign out_ch.no_device     = res_reg.no_device;
    assign out_ch.temperature   = res_reg.temperature;

    `OWTR_ASSERT_NEXT(a_accept_fills, accept, out_valid_reg)
    `OWTR_ASSERT_NOW(a_drive_only_busy, out_valid_reg && res_reg.bus_drive_low, res_reg.busy_res)
    `OWTR_ASSERT_NOW(a_done_only_busy, out_valid_reg && res_reg.done_res, res_reg.busy_res)
    `OWTR_ASSERT_NOW(a_absent_zero, out_valid_reg && res_reg.done_res && res_reg.no_device, res_reg.temperature == 12'd0)

endmodule

// File: test/tb_onewire_temperature_reader_core.sv
// Testbench for the one-wire temperature reader core: tick-level prediction and word checks.
module tb_onewire_temperature_reader_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int CW          = owtr_pkg::CFG_WIDTH;

    class owtr_tick_scoreboard;
        logic [9:0]         rst_len;
        logic [7:0]         pres_len;
        logic [7:0]         slot_len;
        logic [19:0]        conv_len;
        owtr_pkg::phase_t   phase;
        logic [19:0]        timer;
        logic [3:0]         step;
        logic [2:0]         bit_pos;
        logic [7:0]         shift_b;
        logic [7:0]         low_b;
        logic [11:0]        temp;
        logic               absent;
        owtr_pkg::res_t     tick_results[$];
        int                 errors;
        int                 ticks;
        int                 reads_done;
        int                 absents;

        function new();
            rst_len    = owtr_pkg::RESET_LOW_TIME_INIT;
            pres_len   = owtr_pkg::PRESENCE_DELAY_INIT;
            slot_len   = owtr_pkg::SLOT_TIME_INIT;
            conv_len   = owtr_pkg::CONVERT_WAIT_INIT;
            phase      = owtr_pkg::PH_IDLE;
            timer      = '0;
            step       = '0;
            bit_pos    = '0;
            shift_b    = '0;
            low_b      = '0;
            temp       = '0;
            absent     = 1'b0;
            errors     = 0;
            ticks      = 0;
            reads_done = 0;
            absents    = 0;
        endfunction

        function void set_reg(owtr_pkg::cfg_index_t idx, logic [CW-1:0] val);
            case (idx)
                owtr_pkg::CFG_RESET_LOW_TIME: rst_len  = val[9:0];
                owtr_pkg::CFG_PRESENCE_DELAY: pres_len = val[7:0];
                owtr_pkg::CFG_SLOT_TIME:      slot_len = val[7:0];
                default:                      conv_len = val[19:0];
            endcase
        endfunction

        // true on the last tick of a phase of length len (zero acts as one)
        function bit timed(int unsigned len);
            if (timer + 1 >= len)
            begin
                timer = '0;
                return 1'b1;
            end
            timer = timer + 20'd1;
            return 1'b0;
        endfunction

        function void enter_step(logic [3:0] s);
            step    = s;
            timer   = '0;
            bit_pos = '0;
            shift_b = '0;
            if (s == owtr_pkg::STEP_RESET1 || s == owtr_pkg::STEP_RESET2)
                phase = owtr_pkg::PH_RST_LOW;
            else if (s == owtr_pkg::STEP_CONVERT)
                phase = owtr_pkg::PH_CONVERT;
            else if (s >= owtr_pkg::STEP_READ_LO)
                phase = owtr_pkg::PH_RD_LOW;
            else
                phase = owtr_pkg::PH_WR_LOW;
        endfunction

        function void end_read();
            phase   = owtr_pkg::PH_IDLE;
            step    = '0;
            timer   = '0;
            bit_pos = '0;
            reads_done++;
        endfunction

        function logic [7:0] step_cmd();
            if (step == owtr_pkg::STEP_CMD_CONVERT)
                return owtr_pkg::CMD_CONVERT;
            if (step == owtr_pkg::STEP_CMD_READ)
                return owtr_pkg::CMD_READ_PAD;
            return owtr_pkg::CMD_SKIP_ROM;
        endfunction

        function void advance_tick(logic start, logic level);
            owtr_pkg::res_t r;
            logic [7:0]     cmd;
            logic           cmd_bit;
            r = '0;
            r.busy_res = (phase != owtr_pkg::PH_IDLE);
            ticks++;
            case (phase)
                owtr_pkg::PH_RST_LOW:
                begin
                    r.bus_drive_low = 1'b1;
                    if (timed(rst_len))
                        phase = owtr_pkg::PH_RST_WAIT;
                end
                owtr_pkg::PH_RST_WAIT:
                begin
                    if (timed(pres_len))
                    begin
                        if (step == owtr_pkg::STEP_RESET1)
                            absent = level;
                        phase = owtr_pkg::PH_RST_HOLD;
                    end
                end
                owtr_pkg::PH_RST_HOLD:
                begin
                    if (timed(rst_len))
                    begin
                        if (step == owtr_pkg::STEP_RESET1 && absent)
                        begin
                            temp = '0;
                            end_read();
                            r.done_res = 1'b1;
                            absents++;
                        end
                        else
                        begin
                            enter_step(step + 4'd1);
                        end
                    end
                end
                owtr_pkg::PH_WR_LOW:
                begin
                    r.bus_drive_low = 1'b1;
                    cmd = step_cmd();
                    cmd_bit = cmd[bit_pos];
                    if (timed(cmd_bit ? 1 : slot_len))
                        phase = cmd_bit ? owtr_pkg::PH_WR_HIGH : owtr_pkg::PH_RECOVER;
                end
                owtr_pkg::PH_WR_HIGH:
                begin
                    if (timed(slot_len))
                        phase = owtr_pkg::PH_RECOVER;
                end
                owtr_pkg::PH_RD_LOW:
                begin
                    r.bus_drive_low = 1'b1;
                    if (timed(owtr_pkg::READ_LOW_TICKS))
                        phase = owtr_pkg::PH_RD_WAIT;
                end
                owtr_pkg::PH_RD_WAIT:
                begin
                    if (timer == 0)
                        shift_b[bit_pos] = shift_b[bit_pos] | level;
                    if (timed(slot_len))
                        phase = owtr_pkg::PH_RECOVER;
                end
                owtr_pkg::PH_RECOVER:
                begin
                    timer = '0;
                    if (bit_pos < 7)
                    begin
                        bit_pos = bit_pos + 3'd1;
                        phase = (step >= owtr_pkg::STEP_READ_LO) ?
                                owtr_pkg::PH_RD_LOW : owtr_pkg::PH_WR_LOW;
                    end
                    else if (step == owtr_pkg::STEP_READ_LO)
                    begin
                        low_b = shift_b;
                        enter_step(owtr_pkg::STEP_READ_HI);
                    end
                    else if (step >= owtr_pkg::STEP_READ_HI)
                    begin
                        temp = 12'({shift_b, low_b} >> 4);
                        end_read();
                        r.done_res = 1'b1;
                    end
                    else
                    begin
                        enter_step(step + 4'd1);
                    end
                end
                owtr_pkg::PH_CONVERT:
                begin
                    if (timed(conv_len))
                        enter_step(owtr_pkg::STEP_RESET2);
                end
                default:
                begin
                    phase = owtr_pkg::PH_IDLE;
                    if (start)
                    begin
                        absent = 1'b0;
                        enter_step(owtr_pkg::STEP_RESET1);
                    end
                end
            endcase
            r.no_device = absent;
            r.temperature = temp;
            tick_results.push_back(r);
        endfunction

        function void report(string what, owtr_pkg::res_t want, owtr_pkg::res_t got);
            errors++;
            if (errors <= 10)
                $display({"mismatch (%s): expected drv=%0b busy=%0b done=%0b nodev=%0b ",
                          "temp=%0d, got drv=%0b busy=%0b done=%0b nodev=%0b temp=%0d"},
                         what, want.bus_drive_low, want.busy_res, want.done_res,
                         want.no_device, want.temperature, got.bus_drive_low,
                         got.busy_res, got.done_res, got.no_device, got.temperature);
        endfunction

        function void check_word(owtr_pkg::res_t got);
            owtr_pkg::res_t want;
            if (tick_results.size() == 0)
            begin
                report("no word expected", '0, got);
                return;
            end
            want = tick_results.pop_front();
            if (got.bus_drive_low !== want.bus_drive_low || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.no_device !== want.no_device ||
                got.temperature !== want.temperature)
                report("field", want, got);
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    logic [1:0]    cfg_index;
    logic [CW-1:0] cfg_wdata;
    bit            in_idle_on = 1'b1;
    bit            out_idle_on = 1'b1;
    int            reg_writes = 0;

    owtr_in_if  in_ch();
    owtr_out_if out_ch();

    owtr_tick_scoreboard sb = new();

    onewire_temperature_reader_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, checks every accepted word
    initial
    begin
        owtr_pkg::res_t got;
        int             stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.bus_drive_low = out_ch.bus_drive_low;
                got.busy_res      = out_ch.busy_res;
                got.done_res      = out_ch.done_res;
                got.no_device     = out_ch.no_device;
                got.temperature   = out_ch.temperature;
                sb.check_word(got);
                if ($urandom_range(0, 40) == 0)
                    out_idle_on = !out_idle_on;
                stall = out_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic start, input logic level);
        int gap;
        if ($urandom_range(0, 40) == 0)
            in_idle_on = !in_idle_on;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= start;
        in_ch.bus_level <= level;
        do @(posedge clk); while (!in_ch.ready);
        sb.advance_tick(start, level);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.tick_results.size() != 0);
    endtask

    task automatic write_reg(input owtr_pkg::cfg_index_t idx, input logic [CW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, val);
        reg_writes++;
    endtask

    task automatic set_timing(input int unsigned rst, input int unsigned pres,
                              input int unsigned slot, input int unsigned conv);
        drain();
        write_reg(owtr_pkg::CFG_RESET_LOW_TIME, CW'(rst));
        write_reg(owtr_pkg::CFG_PRESENCE_DELAY, CW'(pres));
        write_reg(owtr_pkg::CFG_SLOT_TIME, CW'(slot));
        write_reg(owtr_pkg::CFG_CONVERT_WAIT, CW'(conv));
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // one tick of a device answering presence and returning the reading
    task automatic device_tick(input bit present, input logic [15:0] reading, input bit noisy);
        logic start;
        logic level;
        int   idx;
        idx = (sb.step == owtr_pkg::STEP_READ_HI) ? 8 + int'(sb.bit_pos) : int'(sb.bit_pos);
        case (sb.phase)
            owtr_pkg::PH_RST_WAIT: level = !present;
            owtr_pkg::PH_RD_WAIT:  level = reading[idx];
            default:               level = 1'($urandom_range(0, 1));
        endcase
        if (noisy && $urandom_range(0, 31) == 0)
            level = !level;
        start = noisy ? 1'($urandom_range(0, 3) == 0) : 1'b1;
        send_tick(start, level);
    endtask

    task automatic run_ticks(input bit present, input logic [15:0] reading, input bit noisy,
                             input int n);
        repeat (n)
        begin
            if (sb.phase != owtr_pkg::PH_IDLE)
                device_tick(present, reading, noisy);
        end
    endtask

    task automatic finish_read(input bit present, input logic [15:0] reading, input bit noisy);
        while (sb.phase != owtr_pkg::PH_IDLE)
            device_tick(present, reading, noisy);
    endtask

    task automatic run_read(input bit present, input logic [15:0] reading, input bit noisy);
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        finish_read(present, reading, noisy);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.bus_level = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = owtr_pkg::CFG_RESET_LOW_TIME;
        cfg_wdata       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing for the start of the reset pulse, then shortest timing mid-read;
        // device present, +25.0625 C
        idle_ticks(3);
        send_tick(1'b1, 1'b0);
        run_ticks(1'b1, 16'h0191, 1'b0, 40);
        set_timing(0, 1, 1, 0);
        finish_read(1'b1, 16'h0191, 1'b0);

        // no device
        run_read(1'b0, 16'h1234, 1'b0);

        // widest register values, cut short while the reset pulse runs
        set_timing(1023, 255, 255, 1048575);
        send_tick(1'b1, 1'b0);
        run_ticks(1'b0, 16'h0000, 1'b0, 20);
        set_timing(1, 2, 1, 1);
        finish_read(1'b0, 16'h0000, 1'b0);

        // negative reading wraps
        run_read(1'b1, 16'hFC90, 1'b0);

        while (sb.ticks < 600)
        begin
            if ($urandom_range(0, 1) == 0)
                set_timing($urandom_range(0, 3), $urandom_range(1, 3),
                           $urandom_range(1, 2), $urandom_range(0, 4));
            idle_ticks($urandom_range(0, 4));
            run_read($urandom_range(0, 5) != 0, 16'($urandom), 1'b1);
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.tick_results.size() != 0)
        begin
            sb.errors++;
            $display("%0d expected words never arrived", sb.tick_results.size());
        end
        $display("ran %0d bus ticks over %0d reads (%0d with no device), %0d register writes",
                 sb.ticks, sb.reads_done, sb.absents, reg_writes);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
